### rtl/core/session_slot_table_with_admission_core_assert.svh
// ----------------------------------------------------------------------------
// Session slot table assertion macros
// Shared concurrent assertion forms for the core.
// ----------------------------------------------------------------------------
`ifndef SESSION_SLOT_TABLE_WITH_ADMISSION_CORE_ASSERT_SVH
`define SESSION_SLOT_TABLE_WITH_ADMISSION_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define SST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// Session slot table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int TableSizeDef  = 16;
  localparam int QueueDepthDef = 16;

  typedef enum logic [2:0] {
    REQ_REQUEST = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_RELEASE = 3'd2,
    REQ_CLOSE   = 3'd3,
    REQ_CHECK   = 3'd4,
    REQ_WAIT    = 3'd5
  } req_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_QFULL     = 3'd4;

  localparam logic [0:0] REG_MAX_SESSIONS = 1'b0;
  localparam logic [0:0] REG_THREAD_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch input beat, reset scan index
    logic step;     // advance scan index
    logic do_add;   // write entry at scan index
    logic do_free;  // clear entry at scan index, wake waiter
    logic do_wait;  // enqueue waiter
    logic count;    // count owned match
  } sst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] kind;
    logic       used;
    logic       match_ctx;
    logic       match_hnd;
    logic       scan_end;
    logic       wake_ok;
    logic       wait_refuse;
    logic       wait_qfull;
  } sst_sts_t;

endpackage

### rtl/core/sst_datapath.sv
// ----------------------------------------------------------------------------
// Session slot table datapath
// Entry table, waiter ring, counters and the scan index.
// ----------------------------------------------------------------------------
module sst_datapath #(
  parameter int TABLE_SIZE  = sst_pkg::TableSizeDef,
  parameter int QUEUE_DEPTH = sst_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sst_pkg::sst_cmd_t  cmd,
  output sst_pkg::sst_sts_t  sts,
  input  logic [2:0]         in_kind,
  input  logic [31:0]        in_ctx,
  input  logic [31:0]        in_hnd,
  input  logic [7:0]         in_wid,
  input  logic [7:0]         thread_count,
  output logic [5:0]         owned,
  output logic [7:0]         open_total,
  output logic [7:0]         wake_id
);
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [TABLE_SIZE-1:0]  used_r;
  logic [31:0]            ctx_r [TABLE_SIZE];
  logic [31:0]            hnd_r [TABLE_SIZE];
  logic [QUEUE_DEPTH-1:0] pres_r;
  logic [7:0]             wstore_r [QUEUE_DEPTH];
  logic [QW-1:0]          head_r, tail_r;
  logic [7:0]             open_r, waiting_r;
  logic [TW-1:0]          idx_r;
  logic [2:0]             kind_r;
  logic [31:0]            kctx_r, khnd_r;
  logic [7:0]             kwid_r;
  logic [5:0]             owned_r;

  function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  always_comb begin
    sts.kind        = kind_r;
    sts.used        = used_r[idx_r];
    sts.match_ctx   = ctx_r[idx_r] == kctx_r;
    sts.match_hnd   = hnd_r[idx_r] == khnd_r;
    sts.scan_end    = idx_r == TW'(TABLE_SIZE - 1);
    sts.wake_ok     = pres_r[tail_r];
    sts.wait_refuse = ({1'b0, waiting_r} + 9'd1) >= {1'b0, thread_count};
    sts.wait_qfull  = pres_r[head_r];
  end

  assign owned      = owned_r;
  assign open_total = open_r;
  assign wake_id    = wstore_r[tail_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      pres_r    <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      open_r    <= '0;
      waiting_r <= '0;
      idx_r     <= '0;
      owned_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r   <= '0;
        owned_r <= '0;
        kind_r  <= in_kind;
        kctx_r  <= in_ctx;
        khnd_r  <= in_hnd;
        kwid_r  <= in_wid;
      end else if (cmd.step) begin
        idx_r <= idx_r + TW'(1);
      end
      if (cmd.count) owned_r <= owned_r + 6'd1;
      if (cmd.do_add) begin
        used_r[idx_r] <= 1'b1;
        ctx_r[idx_r]  <= kctx_r;
        hnd_r[idx_r]  <= khnd_r;
        if (open_r != 8'hFF) open_r <= open_r + 8'd1;
      end
      if (cmd.do_free) begin
        used_r[idx_r] <= 1'b0;
        if (open_r != 8'd0) open_r <= open_r - 8'd1;
        if (pres_r[tail_r]) begin
          pres_r[tail_r] <= 1'b0;
          tail_r         <= qinc(tail_r);
          if (waiting_r != 8'd0) waiting_r <= waiting_r - 8'd1;
        end
      end
      if (cmd.do_wait) begin
        wstore_r[head_r] <= kwid_r;
        pres_r[head_r]   <= 1'b1;
        head_r           <= qinc(head_r);
        if (waiting_r != 8'hFF) waiting_r <= waiting_r + 8'd1;
      end
    end
  end
endmodule

### rtl/core/sst_ctrl.sv
// ----------------------------------------------------------------------------
// Session slot table controller
// Sequences the table scan and drives the output register.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [2:0]        o_status,
  output logic              o_grant,
  output logic              o_wake,
  output logic              o_last,
  output logic              o_use_owned,
  output logic [7:0]        o_wake_id,
  output sst_pkg::sst_cmd_t cmd,
  input  sst_pkg::sst_sts_t sts,
  input  logic [7:0]        max_sessions,
  input  logic [5:0]        owned,
  input  logic [7:0]        open_total,
  input  logic [7:0]        wake_id
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} state_t;
  state_t state_r;
  logic   found_r;
  logic   hit, out_free;
  logic   beat_wake, beat_done;
  logic [7:0] limit, freeslots;
  logic [2:0] status_nxt;
  logic       grant_nxt;

  assign in_tready = state_r == S_IDLE;
  assign out_free  = !out_tvalid || out_tready;
  assign hit       = sts.used && sts.match_ctx;
  assign limit     = (max_sessions[7:1] < 7'd2) ? 8'd2 : {1'b0, max_sessions[7:1]};
  assign freeslots = (max_sessions > open_total) ? max_sessions - open_total : 8'd0;

  always_comb begin
    cmd = '0;
    cmd.load = in_tvalid && state_r == S_IDLE;
    if (state_r == S_SCAN && out_free && !found_r) begin
      unique case (sts.kind)
        sst_pkg::REQ_REQUEST: cmd.count = hit;
        sst_pkg::REQ_ADD:     cmd.do_add = !sts.used;
        sst_pkg::REQ_RELEASE: cmd.do_free = hit && sts.match_hnd;
        sst_pkg::REQ_CLOSE:   cmd.do_free = hit;
        default: ;
      endcase
      cmd.step = !sts.scan_end;
    end
    if (state_r == S_DONE && out_free)
      cmd.do_wait = sts.kind == sst_pkg::REQ_WAIT && !sts.wait_refuse && !sts.wait_qfull;
  end

  // wake beats go out mid-scan, the final beat from S_DONE
  assign beat_wake = state_r == S_SCAN && out_free && !found_r && cmd.do_free && sts.wake_ok;
  assign beat_done = state_r == S_DONE && out_free;

  always_comb begin
    status_nxt = sst_pkg::ST_OK;
    grant_nxt  = 1'b0;
    unique case (sts.kind)
      sst_pkg::REQ_REQUEST:
        grant_nxt = ({2'b0, owned} < limit) &&
                    ((owned != 6'd0 && freeslots >= 8'd1) || freeslots >= 8'd2);
      sst_pkg::REQ_ADD:   if (!found_r) status_nxt = sst_pkg::ST_FULL;
      sst_pkg::REQ_CHECK: if (!found_r) status_nxt = sst_pkg::ST_NOT_FOUND;
      sst_pkg::REQ_WAIT:
        if (sts.wait_refuse) status_nxt = sst_pkg::ST_TOO_MANY;
        else if (sts.wait_qfull) status_nxt = sst_pkg::ST_QFULL;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (beat_wake || beat_done) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (beat_wake) begin
        o_status <= sst_pkg::ST_OK; o_grant <= 1'b0; o_wake <= 1'b1;
        o_last <= 1'b0; o_use_owned <= 1'b0; o_wake_id <= wake_id;
      end else if (beat_done) begin
        o_status <= status_nxt; o_grant <= grant_nxt; o_wake <= 1'b0;
        o_last <= 1'b1; o_use_owned <= sts.kind == sst_pkg::REQ_REQUEST;
        o_wake_id <= 8'd0;
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          found_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: if (out_free) begin
          if (!found_r && (cmd.do_add ||
              (sts.kind == sst_pkg::REQ_CHECK && hit && sts.match_hnd)))
            found_r <= 1'b1;
          if (sts.scan_end || found_r) state_r <= S_DONE;
        end
        S_DONE: if (out_free) state_r <= S_OUT;
        S_OUT: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/session_slot_table_with_admission_core.sv
// ----------------------------------------------------------------------------
// Session slot table with admission control
// Top level: APB registers, stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// Each request scans the session table one entry per cycle; release and close
// emit one extra beat per woken waiter, and the scan pauses while a beat waits
// at the output register. A new request is taken only once the previous one
// has finished (in_tready is high only in the idle state).
module session_slot_table_with_admission_core #(
  parameter int TABLE_SIZE  = sst_pkg::TableSizeDef,
  parameter int QUEUE_DEPTH = sst_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[2:0], ctx_id[34:3], session_handle[66:35], waiter_id[74:67]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], grant[3], owned_count[9:4], wake_valid[10], wake_waiter[18:11]
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [7:0] max_r, thr_r;
  sst_pkg::sst_cmd_t cmd;
  sst_pkg::sst_sts_t sts;
  logic [5:0] owned;
  logic [7:0] open_total, wake_id, o_wake_id;
  logic [2:0] o_status;
  logic o_grant, o_wake, o_use;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 8'd3;
      thr_r <= 8'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == sst_pkg::REG_MAX_SESSIONS) max_r <= cfg_pwdata[7:0];
      if (cfg_paddr[2] == sst_pkg::REG_THREAD_COUNT) thr_r <= cfg_pwdata[7:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == sst_pkg::REG_MAX_SESSIONS) ? {24'd0, max_r}
                                                                  : {24'd0, thr_r};

  sst_datapath #(.TABLE_SIZE(TABLE_SIZE), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_kind(in_tdata[2:0]), .in_ctx(in_tdata[34:3]), .in_hnd(in_tdata[66:35]),
    .in_wid(in_tdata[74:67]), .thread_count(thr_r),
    .owned, .open_total, .wake_id
  );

  sst_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .o_status, .o_grant, .o_wake, .o_last(out_tlast), .o_use_owned(o_use),
    .o_wake_id, .cmd, .sts, .max_sessions(max_r), .owned, .open_total, .wake_id
  );

  assign out_tdata = {5'd0, o_wake_id, o_wake, (o_use ? owned : 6'd0), o_grant, o_status};

  `include "session_slot_table_with_admission_core_assert.svh"

  `SST_ASSERT_IMP(a_no_accept_busy, in_tvalid && !in_tready, !cmd.load)
  `SST_ASSERT_IMP(a_wake_not_last, out_tvalid && out_tdata[10], !out_tlast)
  `SST_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid)
endmodule
